[sv/hse_pkg.sv]
// Shared types and codes for the hash set engine.
// No dependencies; imported by the controller, the datapath and the top level.
package hse_pkg;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_CONTAINS = 2'd2;

	typedef struct packed {
		logic load_req;
		logic rd_en;
		logic wr_en;
		logic clr_wr;
		logic out_load;
	} hse_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic clr_last;
	} hse_sts_t;

endpackage

[sv/hse_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hse_ram #(
	parameter int WIDTH = 84,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/hse_mod.sv]
// Bucket index unit: key modulo NUM_BUCKETS.
// Slices the key for a power-of-two bucket count, else a reciprocal multiply, 16 bits a cycle.
module hse_mod #(
	parameter int NUM_BUCKETS = 1024,
	parameter int KEY_BITS    = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [KEY_BITS-1:0]            key,
	output logic                           done,
	output logic [$clog2(NUM_BUCKETS)-1:0] rem
);

	localparam int BW      = $clog2(NUM_BUCKETS);
	localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

	logic [BW-1:0] rem_q;
	logic          done_q;

	generate
		if (IS_POW2) begin : g_pow2
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (start) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= BW'(key);
				end
			end
		end else begin : g_recip
			localparam int MW = KEY_BITS + 2;
			localparam int NC = (MW + 15) / 16;
			localparam int AW = KEY_BITS + MW;
			localparam int SH = KEY_BITS + BW;
			localparam int CW = $clog2(NC + 1);
			localparam logic [127:0] MU_W =
				((128'd1 << SH) + 128'(NUM_BUCKETS) - 128'd1) / 128'(NUM_BUCKETS);
			localparam logic [16*NC-1:0] MU = (16*NC)'(MU_W);
			localparam logic [BW-1:0]    NB = BW'(NUM_BUCKETS);

			logic [CW-1:0]       cnt_q;
			logic                fin_q;
			logic [KEY_BITS-1:0] key_q;
			logic [16*NC-1:0]    mu_q;
			logic [AW-1:0]       acc_q;
			logic [KEY_BITS+15:0] prod;
			logic [AW+15:0]      acc_d;
			logic [AW-1:0]       quo;

			always_comb begin
				prod  = (KEY_BITS + 16)'(key_q) * (KEY_BITS + 16)'(mu_q[16*NC-1 -: 16]);
				acc_d = {acc_q, 16'd0} + (AW + 16)'(prod);
				quo   = acc_q >> SH;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q  <= '0;
					fin_q  <= 1'b0;
					done_q <= 1'b0;
				end else if (start) begin
					cnt_q  <= CW'(NC);
					fin_q  <= 1'b0;
					done_q <= 1'b0;
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
					fin_q <= (cnt_q == CW'(1));
				end else if (fin_q) begin
					fin_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					mu_q  <= MU;
					acc_q <= '0;
				end else if (cnt_q != '0) begin
					mu_q  <= mu_q << 16;
					acc_q <= acc_d[AW-1:0];
				end
				if (fin_q) begin
					rem_q <= BW'(key_q) - BW'(quo) * NB;
				end
			end
		end
	endgenerate

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[sv/hse_dp.sv]
// Datapath: request registers, bucket index unit, bucket row memory, way compare,
// row update and result registers. Depends on hse_pkg, hse_mod and hse_ram.
module hse_dp
	import hse_pkg::*;
#(
	parameter int NUM_BUCKETS = 1024,
	parameter int WAYS        = 4,
	parameter int KEY_BITS    = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hse_cmd_t            cmd,
	output hse_sts_t            sts,
	input  logic [1:0]          op,
	input  logic [KEY_BITS-1:0] key,
	output logic                present,
	output logic                bucket_full
);

	localparam int BW     = $clog2(NUM_BUCKETS);
	localparam int SLOT_W = KEY_BITS + 1;
	localparam int ROW_W  = WAYS * SLOT_W;

	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BW-1:0]       clr_q;
	logic                present_q;
	logic                full_q;

	logic                mod_done;
	logic [BW-1:0]       bucket;
	logic [ROW_W-1:0]    row;
	logic [ROW_W-1:0]    new_row;
	logic [ROW_W-1:0]    wr_data;
	logic [BW-1:0]       wr_addr;

	logic [WAYS-1:0]     hit_v;
	logic [WAYS-1:0]     free_v;
	logic [WAYS-1:0]     hit_oh;
	logic [WAYS-1:0]     free_oh;
	logic                hit;
	logic                have_free;
	logic                do_add;
	logic                do_rem;
	logic                full;

	hse_mod #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.KEY_BITS   (KEY_BITS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.load_req),
		.key   (key),
		.done  (mod_done),
		.rem   (bucket)
	);

	hse_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en | cmd.clr_wr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(bucket),
		.rd_data(row)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_v[w]  = row[w*SLOT_W+KEY_BITS] && (row[w*SLOT_W +: KEY_BITS] == key_q);
			free_v[w] = !row[w*SLOT_W+KEY_BITS];
		end
		hit_oh    = hit_v & (~hit_v + WAYS'(1));
		free_oh   = free_v & (~free_v + WAYS'(1));
		hit       = |hit_v;
		have_free = |free_v;
		do_add    = (op_q == OP_ADD) && !hit && have_free;
		do_rem    = (op_q == OP_REMOVE) && hit;
		full      = (op_q == OP_ADD) && !hit && !have_free;
		new_row   = row;
		for (int w = 0; w < WAYS; w++) begin
			if (do_add && free_oh[w]) begin
				new_row[w*SLOT_W +: SLOT_W] = {1'b1, key_q};
			end
			if (do_rem && hit_oh[w]) begin
				new_row[w*SLOT_W+KEY_BITS] = 1'b0;
			end
		end
	end

	assign wr_addr = cmd.clr_wr ? clr_q : bucket;
	assign wr_data = cmd.clr_wr ? '0 : new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= op;
			key_q <= key;
		end
		if (cmd.out_load) begin
			present_q <= hit;
			full_q    <= full;
		end
	end

	assign sts.mod_done = mod_done;
	assign sts.clr_last = (clr_q == BW'(NUM_BUCKETS - 1));
	assign present      = present_q;
	assign bucket_full  = full_q;

endmodule

[sv/hse_ctrl.sv]
// Controller: clearing pass, request sequencing and output valid register.
// Depends on hse_pkg; drives the datapath through hse_cmd_t.
module hse_ctrl
	import hse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  hse_sts_t sts,
	output hse_cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_MOD   = 2'd2;
	localparam logic [1:0] ST_CMP   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_MOD;
				end
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				if (out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.wr_en, cmd.rd_en, cmd.load_req}))
		else $error("memory commands overlap");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (in_stall && !out_valid_q))
		else $error("request path active during clearing pass");
`endif

endmodule

[sv/hash_set_engine.sv]
// Top level of the hash set engine: controller plus datapath.
// Depends on hse_pkg, hse_ctrl and hse_dp.
//
//   channel   handshake            payload
//   request   in_valid / in_stall  op[1:0], key[KEY_BITS-1:0]
//   result    out_valid/ out_stall present, bucket_full
//
// A request passes through the remainder unit (a key slice when NUM_BUCKETS is a power of two,
// else a reciprocal multiply, 16 bits a cycle) and then the row read-modify-write.
// After reset a clearing pass writes every bucket row, with in_stall high.
// A result waits in an output register; the next request is taken meanwhile.
// A stalled result holds the request in the compare step until the register frees.
module hash_set_engine
	import hse_pkg::*;
#(
	parameter int NUM_BUCKETS = 1024,
	parameter int WAYS        = 4,
	parameter int KEY_BITS    = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [KEY_BITS-1:0] key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                present,
	output logic                bucket_full
);

	hse_cmd_t cmd;
	hse_sts_t sts;

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hse_dp #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS       (WAYS),
		.KEY_BITS   (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.key        (key),
		.present    (present),
		.bucket_full(bucket_full)
	);

`ifndef NO_ASSERTIONS
	a_full_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bucket_full) |-> !present)
		else $error("dropped add reported a present key");
`endif

endmodule
